>>> rtl/core/sjs_pkg.sv
// Package for the scan jump segmenter: shared constants, register indexes,
// the back-end state type and the CORDIC arctangent table.
// Used by every module under rtl/core.
package sjs_pkg;

  localparam int RANGE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // CORDIC in Q30 with a 32-bit phase, full turn = 2^32.
  localparam int CORDIC_N   = 16;
  localparam int ITER_BITS  = $clog2(CORDIC_N);
  localparam int CW         = 34;   // width of the CORDIC x and y registers
  localparam int ZW         = 33;   // width of the residual angle register
  localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;

  localparam int JUMP_RESET = 40;

  typedef enum logic [2:0] {
    REG_ANGLE_START    = 3'd0,
    REG_ANGLE_STEP     = 3'd1,
    REG_RANGE_LOW      = 3'd2,
    REG_RANGE_HIGH     = 3'd3,
    REG_JUMP_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_MUL,
    S_SCALE,
    S_SQ,
    S_CMP,
    S_OUT
  } back_state_t;

  // Status flags of the queue, read by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  function automatic logic [31:0] atan_val(input logic [ITER_BITS-1:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/sjs_front.sv
// Front end: configuration registers, sample angle tracking and range
// classification. Pushes kept samples and scan ends into the queue. Uses sjs_pkg.
module sjs_front #(
  parameter int RANGE_BITS = sjs_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = sjs_pkg::ANGLE_BITS_DEF,
  parameter int CFG_BITS   = (RANGE_BITS > ANGLE_BITS) ? RANGE_BITS : ANGLE_BITS,
  parameter int EW         = RANGE_BITS + ANGLE_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [RANGE_BITS-1:0] in_range,
  input  logic                  in_last,
  input  sjs_pkg::queue_stat_t  q_stat,
  output logic                  q_push,
  output logic [EW-1:0]         q_wdata,
  output logic [RANGE_BITS-1:0] jump_threshold
);
  import sjs_pkg::*;

  logic [ANGLE_BITS-1:0] angle_start_r, angle_step_r, cur_angle_r, cur_angle_nxt;
  logic [RANGE_BITS-1:0] range_low_r, range_high_r, jump_r;
  logic                  accept, keep;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign keep      = (in_range >= range_low_r) && (in_range <= range_high_r);
  assign q_push    = accept && (keep || in_last);
  assign q_wdata   = {in_last, keep, cur_angle_r, in_range};
  assign jump_threshold = jump_r;

  always_comb begin
    cur_angle_nxt = cur_angle_r;
    if (cfg_we && cfg_reg_t'(cfg_index) == REG_ANGLE_START) begin
      cur_angle_nxt = cfg_wdata[ANGLE_BITS-1:0];
    end else if (accept) begin
      cur_angle_nxt = in_last ? angle_start_r : cur_angle_r + angle_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= '0;
      angle_step_r  <= '0;
      range_low_r   <= '0;
      range_high_r  <= '1;
      jump_r        <= RANGE_BITS'(JUMP_RESET);
      cur_angle_r   <= '0;
    end else begin
      cur_angle_r <= cur_angle_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ANGLE_START:    angle_start_r <= cfg_wdata[ANGLE_BITS-1:0];
          REG_ANGLE_STEP:     angle_step_r  <= cfg_wdata[ANGLE_BITS-1:0];
          REG_RANGE_LOW:      range_low_r   <= cfg_wdata[RANGE_BITS-1:0];
          REG_RANGE_HIGH:     range_high_r  <= cfg_wdata[RANGE_BITS-1:0];
          REG_JUMP_THRESHOLD: jump_r        <= cfg_wdata[RANGE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/sjs_queue.sv
// Small first-in first-out queue between the front and back ends.
// Uses sjs_pkg for the status struct.
module sjs_queue #(
  parameter int EW    = 34,
  parameter int DEPTH = sjs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [EW-1:0]        wdata,
  input  logic                 pop,
  output logic [EW-1:0]        rdata,
  output sjs_pkg::queue_stat_t stat
);
  import sjs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [EW-1:0]   mem [DEPTH];
  logic [IW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNTW'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/core/sjs_back.sv
// Back end: iterative CORDIC, range scaling with rounding and saturation,
// jump test against the previous point, and the output register. Uses sjs_pkg.
module sjs_back #(
  parameter int RANGE_BITS = sjs_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = sjs_pkg::ANGLE_BITS_DEF,
  parameter int EW         = RANGE_BITS + ANGLE_BITS + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sjs_pkg::queue_stat_t        q_stat,
  input  logic [EW-1:0]               q_rdata,
  output logic                        q_pop,
  input  logic [RANGE_BITS-1:0]       jump_threshold,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RANGE_BITS:0]  out_x,
  output logic signed [RANGE_BITS:0]  out_y,
  output logic                        out_has_point,
  output logic                        out_start,
  output logic                        out_eos
);
  import sjs_pkg::*;

  localparam int PW = RANGE_BITS + 1 + CW;      // product width
  localparam int DW = RANGE_BITS + 2;           // coordinate difference width
  localparam int SW = 2 * DW;                   // square width
  localparam logic signed [PW-1:0] RND = PW'(64'sd536870912);
  localparam logic signed [PW-1:0] LIM = PW'((64'sd1 <<< RANGE_BITS) - 64'sd1);

  back_state_t state_r, state_nxt;

  logic [RANGE_BITS-1:0]     range_r;
  logic [1:0]                quad_r;
  logic                      last_r;
  logic signed [CW-1:0]      cx_r, cy_r, cx_nxt, cy_nxt, shx, shy, cval, sval;
  logic signed [ZW-1:0]      z_r, z_nxt, atan_s;
  logic [ITER_BITS-1:0]      iter_r;
  logic signed [PW-1:0]      prod_c_r, prod_s_r, vx, vy;
  logic signed [RANGE_BITS:0] px_r, py_r, prev_x_r, prev_y_r;
  logic                      have_prev_r;
  logic signed [DW-1:0]      dx, dy;
  logic signed [SW-1:0]      sq_x_r, sq_y_r;
  logic [2*RANGE_BITS-1:0]   thr_sq_r;
  logic [SW:0]               d2;
  logic                      jump;

  // Result held between the compare step and the output register.
  logic signed [RANGE_BITS:0] res_x_r, res_y_r;
  logic                       res_has_r, res_start_r, res_eos_r;

  logic                      ent_last, ent_keep;
  logic [ANGLE_BITS-1:0]     ent_angle;
  logic [RANGE_BITS-1:0]     ent_range;
  logic [31:0]               phase;
  logic                      out_free;

  assign ent_range = q_rdata[RANGE_BITS-1:0];
  assign ent_angle = q_rdata[RANGE_BITS +: ANGLE_BITS];
  assign ent_keep  = q_rdata[RANGE_BITS+ANGLE_BITS];
  assign ent_last  = q_rdata[RANGE_BITS+ANGLE_BITS+1];
  assign phase     = {ent_angle, {(32-ANGLE_BITS){1'b0}}};

  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign out_free = !out_valid || out_ready;

  // One CORDIC rotation step.
  always_comb begin
    shx    = cy_r >>> iter_r;
    shy    = cx_r >>> iter_r;
    atan_s = $signed({1'b0, atan_val(iter_r)});
    if (!z_r[ZW-1]) begin
      cx_nxt = cx_r - shx;
      cy_nxt = cy_r + shy;
      z_nxt  = z_r - atan_s;
    end else begin
      cx_nxt = cx_r + shx;
      cy_nxt = cy_r - shy;
      z_nxt  = z_r + atan_s;
    end
  end

  // Quadrant fold-back by swapping and negating.
  always_comb begin
    case (quad_r)
      2'd0:    begin cval = cx_r;  sval = cy_r;  end
      2'd1:    begin cval = -cy_r; sval = cx_r;  end
      2'd2:    begin cval = -cx_r; sval = -cy_r; end
      default: begin cval = cy_r;  sval = -cx_r; end
    endcase
  end

  assign vx = (prod_c_r + RND) >>> 30;
  assign vy = (prod_s_r + RND) >>> 30;
  assign dx = DW'(px_r) - DW'(prev_x_r);
  assign dy = DW'(py_r) - DW'(prev_y_r);
  assign d2 = (SW+1)'(unsigned'(sq_x_r)) + (SW+1)'(unsigned'(sq_y_r));
  assign jump = d2 > (SW+1)'(thr_sq_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ent_keep ? S_ROT : S_OUT;
        end
      end
      S_ROT: begin
        if (iter_r == ITER_BITS'(CORDIC_N - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_SQ;
      S_SQ:    state_nxt = S_CMP;
      S_CMP:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && !q_stat.empty && !ent_keep) begin
        // A rejected sample only reaches the back end when it ends the scan.
        have_prev_r <= 1'b0;
      end
      if (state_r == S_CMP) begin
        prev_x_r    <= px_r;
        prev_y_r    <= py_r;
        have_prev_r <= !last_r;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        range_r     <= ent_range;
        quad_r      <= phase[31:30];
        last_r      <= ent_last;
        cx_r        <= CW'($signed({1'b0, CORDIC_K}));
        cy_r        <= '0;
        z_r         <= ZW'({1'b0, phase[29:0]});
        iter_r      <= '0;
        res_x_r     <= '0;
        res_y_r     <= '0;
        res_has_r   <= 1'b0;
        res_start_r <= 1'b0;
        res_eos_r   <= ent_last;
      end
      S_ROT: begin
        cx_r   <= cx_nxt;
        cy_r   <= cy_nxt;
        z_r    <= z_nxt;
        iter_r <= iter_r + 1'b1;
      end
      S_MUL: begin
        prod_c_r <= PW'($signed({1'b0, range_r}) * cval);
        prod_s_r <= PW'($signed({1'b0, range_r}) * sval);
      end
      S_SCALE: begin
        px_r <= (vx > LIM) ? LIM[RANGE_BITS:0] : (vx < -LIM) ? -LIM[RANGE_BITS:0]
                                                           : vx[RANGE_BITS:0];
        py_r <= (vy > LIM) ? LIM[RANGE_BITS:0] : (vy < -LIM) ? -LIM[RANGE_BITS:0]
                                                           : vy[RANGE_BITS:0];
      end
      S_SQ: begin
        sq_x_r   <= dx * dx;
        sq_y_r   <= dy * dy;
        thr_sq_r <= jump_threshold * jump_threshold;
      end
      S_CMP: begin
        res_x_r     <= px_r;
        res_y_r     <= py_r;
        res_has_r   <= 1'b1;
        res_start_r <= !have_prev_r || jump;
        res_eos_r   <= last_r;
      end
      S_OUT: begin
        if (out_free) begin
          out_x         <= res_x_r;
          out_y         <= res_y_r;
          out_has_point <= res_has_r;
          out_start     <= res_start_r;
          out_eos       <= res_eos_r;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/scan_jump_segmenter_top.sv
// Scan jump segmenter, top level: laser range samples in, x/y points with
// cluster start and end-of-scan marks out. Uses sjs_pkg, sjs_front, sjs_queue, sjs_back.
//
// Usage:
//   in_*   : one range sample per transfer, in_tlast on the last sample of a scan.
//   out_*  : zero or one result per sample; out_tlast marks the scan's end,
//            out_tuser carries has_point and cluster_start.
//   cfg_*  : register writes, taken whenever cfg_we is high, index 0..4 as
//            angle_start, angle_step, range_low, range_high, jump_threshold.
//            Write only while no sample is in flight.
// Flow: a kept sample goes from the queue through the 16-step iterative CORDIC,
//   the multiply, scaling, square and compare steps and the output state to the
//   output register; the back end works on one sample at a time and takes no new
//   sample from the queue until the last has left the output state. A rejected
//   sample that is not the last of a scan gives no result; a rejected last sample
//   goes from the queue straight to the output state and gives its end marker.
// Reset: synchronous, active low; registers take their reset values and the
//   queue and output register empty. A stalled receiver holds the result in the
//   output register; the back end and then the two-entry queue fill before
//   in_tready drops.
module scan_jump_segmenter_top #(
  parameter int RANGE_BITS = sjs_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = sjs_pkg::ANGLE_BITS_DEF,
  parameter int CFG_BITS   = (RANGE_BITS > ANGLE_BITS) ? RANGE_BITS : ANGLE_BITS,
  parameter int IN_BYTES   = (RANGE_BITS + 7) / 8,
  parameter int OUT_BYTES  = (2 * RANGE_BITS + 2 + 7) / 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [8*IN_BYTES-1:0]  in_tdata,   // range_mm
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [8*OUT_BYTES-1:0] out_tdata,  // point_x, point_y
  output logic [1:0]             out_tuser,  // has_point, cluster_start
  output logic                   out_tlast   // end_of_scan
);
  import sjs_pkg::*;

  localparam int EW = RANGE_BITS + ANGLE_BITS + 2;

  queue_stat_t                q_stat;
  logic                       q_push, q_pop;
  logic [EW-1:0]              q_wdata, q_rdata;
  logic [RANGE_BITS-1:0]      jump_threshold;
  logic signed [RANGE_BITS:0] point_x, point_y;
  logic                       has_point, cluster_start;

  sjs_front #(
    .RANGE_BITS(RANGE_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .CFG_BITS  (CFG_BITS),
    .EW        (EW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_range      (in_tdata[RANGE_BITS-1:0]),
    .in_last       (in_tlast),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .jump_threshold(jump_threshold)
  );

  sjs_queue #(
    .EW   (EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  sjs_back #(
    .RANGE_BITS(RANGE_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .EW        (EW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .jump_threshold(jump_threshold),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_x         (point_x),
    .out_y         (point_y),
    .out_has_point (has_point),
    .out_start     (cluster_start),
    .out_eos       (out_tlast)
  );

  assign out_tdata = (8*OUT_BYTES)'({point_y, point_x});
  assign out_tuser = {cluster_start, has_point};

endmodule

>>> test/scan_point_checker.sv
// Scoreboard for the scan jump segmenter: follows the register port and the
// sample stream, predicts each point or end marker, and compares the results.
// Depends on sjs_pkg for the register indexes and the CORDIC gain constant.
module scan_point_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // range_mm
  input  logic        in_tlast,   // last_sample
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // point_x, point_y
  input  logic [1:0]  out_tuser,  // has_point, cluster_start
  input  logic        out_tlast,  // end_of_scan
  output int          mismatch_count,
  output int          points_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sjs_pkg::*;

  localparam int     RB           = RANGE_BITS_DEF;
  localparam int     AB           = ANGLE_BITS_DEF;
  localparam int     REPORT_LIMIT = 10;
  localparam longint HALF_LSB     = 64'sd1 <<< 29;
  localparam longint SAT_MAG      = (64'sd1 <<< RB) - 64'sd1;

  // Arctangent of 2^-i in phase units, 2^32 per full turn.
  localparam longint ATAN_STEP [CORDIC_N] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct {
    logic signed [RB:0] x;
    logic signed [RB:0] y;
    logic               has_pt;
    logic               opens;
    logic               eos;
  } scan_result_t;

  scan_result_t   awaited_points[$];
  logic [AB-1:0]  start_angle, angle_inc, sample_angle;
  logic [RB-1:0]  win_low, win_high, jump_mm;
  longint         prev_x, prev_y;
  bit             have_prev;
  int             mism;

  function automatic longint clip_scale(input longint rng, input longint c);
    longint v;
    v = (rng * c + HALF_LSB) >>> 30;
    if (v > SAT_MAG) v = SAT_MAG;
    if (v < -SAT_MAG) v = -SAT_MAG;
    return v;
  endfunction

  function automatic void rotate_point(input longint rng, input logic [AB-1:0] ang,
                                       output longint px, output longint py);
    logic [31:0] phase;
    longint      cx, cy, z, tx, cosv, sinv;
    phase = 32'(ang) << (32 - AB);
    cx    = longint'(CORDIC_K);
    cy    = 0;
    z     = longint'(phase[29:0]);
    for (int i = 0; i < CORDIC_N; i++) begin
      tx = cx;
      if (z >= 0) begin
        cx = cx - (cy >>> i);
        cy = cy + (tx >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        cx = cx + (cy >>> i);
        cy = cy - (tx >>> i);
        z  = z + ATAN_STEP[i];
      end
    end
    // The quadrant is applied exactly after the first-quadrant rotation.
    case (phase[31:30])
      2'd0: begin cosv = cx;  sinv = cy;  end
      2'd1: begin cosv = -cy; sinv = cx;  end
      2'd2: begin cosv = -cx; sinv = -cy; end
      default: begin cosv = cy; sinv = -cx; end
    endcase
    px = clip_scale(rng, cosv);
    py = clip_scale(rng, sinv);
  endfunction

  task automatic segment_sample(input logic [RB-1:0] rng, input logic last_s);
    logic [AB-1:0] ang;
    longint        px, py, ddx, ddy, d2;
    scan_result_t  r;
    ang          = sample_angle;
    sample_angle = sample_angle + angle_inc;
    if (rng >= win_low && rng <= win_high) begin
      rotate_point(longint'(rng), ang, px, py);
      if (!have_prev) begin
        r.opens = 1'b1;
      end else begin
        ddx     = px - prev_x;
        ddy     = py - prev_y;
        d2      = ddx * ddx + ddy * ddy;
        r.opens = d2 > longint'(jump_mm) * longint'(jump_mm);
      end
      prev_x    = px;
      prev_y    = py;
      have_prev = 1'b1;
      r.x       = px[RB:0];
      r.y       = py[RB:0];
      r.has_pt  = 1'b1;
      r.eos     = last_s;
      awaited_points.insert(awaited_points.size(), r);
    end else if (last_s) begin
      r = '{x: '0, y: '0, has_pt: 1'b0, opens: 1'b0, eos: 1'b1};
      awaited_points.insert(awaited_points.size(), r);
    end
    if (last_s) begin
      sample_angle = start_angle;
      have_prev    = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mism++;
    if (mism <= REPORT_LIMIT) $display("%s", what);
  endtask

  always @(posedge clk) begin : watch
    scan_result_t want, got;
    if (!rst_n) begin
      start_angle  = '0;
      angle_inc    = '0;
      win_low      = '0;
      win_high     = '1;
      jump_mm      = RB'(JUMP_RESET);
      sample_angle = '0;
      prev_x       = 0;
      prev_y       = 0;
      have_prev    = 1'b0;
      awaited_points.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.x      = out_tdata[RB:0];
        got.y      = out_tdata[2*RB+1:RB+1];
        got.has_pt = out_tuser[0];
        got.opens  = out_tuser[1];
        got.eos    = out_tlast;
        if (awaited_points.size() == 0) begin
          flag_mismatch($sformatf("unexpected result x=%0d y=%0d pt=%b start=%b eos=%b",
                                  got.x, got.y, got.has_pt, got.opens, got.eos));
        end else begin
          want = awaited_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.has_pt !== want.has_pt ||
              got.opens !== want.opens || got.eos !== want.eos)
            flag_mismatch($sformatf(
              "expected x=%0d y=%0d pt=%b start=%b eos=%b got x=%0d y=%0d pt=%b start=%b eos=%b",
              want.x, want.y, want.has_pt, want.opens, want.eos,
              got.x, got.y, got.has_pt, got.opens, got.eos));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_START: begin
            start_angle  = cfg_wdata[AB-1:0];
            sample_angle = cfg_wdata[AB-1:0];
          end
          REG_ANGLE_STEP:     angle_inc = cfg_wdata[AB-1:0];
          REG_RANGE_LOW:      win_low   = cfg_wdata[RB-1:0];
          REG_RANGE_HIGH:     win_high  = cfg_wdata[RB-1:0];
          REG_JUMP_THRESHOLD: jump_mm   = cfg_wdata[RB-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) segment_sample(in_tdata[RB-1:0], in_tlast);
    end
    points_pending <= awaited_points.size();
    mismatch_count <= mism;
  end

endmodule

>>> test/tb_scan_jump_segmenter_top.sv
// Testbench top for the scan jump segmenter: clock, reset, register writes,
// range sample stimulus and the final verdict. Depends on sjs_pkg, the RTL
// top level and scan_point_checker, which does the prediction and compare.
module tb_scan_jump_segmenter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sjs_pkg::*;

  localparam int         SETTLE_CYCLES     = 40;
  localparam int         PHASE_ITEMS       = 100;
  localparam logic [2:0] SPARE_INDEX_FIRST = 3'd5;
  localparam logic [2:0] SPARE_INDEX_LAST  = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // range_mm
  logic        in_tlast   = 1'b0; // last_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // point_x, point_y
  logic [1:0]  out_tuser;         // has_point, cluster_start
  logic        out_tlast;         // end_of_scan

  int          mismatch_count;
  int          points_pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [15:0] cur_low, cur_high;

  scan_jump_segmenter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scan_point_checker point_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .points_pending (points_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] rng, input logic last_s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rng;
    in_tlast  <= last_s;
    do @(posedge clk); while (!in_tready);
  endtask

  // Samples that are rejected and not last give no result; they are dropped at
  // the input and are not held in the block after the last expected result.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end while (points_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic pick_settings();
    logic [15:0] a_step, thr;
    int          sel;
    sel = $urandom_range(3);
    case (sel)
      0: a_step = 16'($urandom_range(64));
      1: a_step = 16'($urandom_range(1024));
      2: a_step = 16'($urandom);
      default: a_step = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    sel = $urandom_range(9);
    if (sel == 0) begin
      cur_low  = 16'h0000;
      cur_high = 16'hFFFF;
    end else if (sel == 1) begin
      cur_low  = 16'($urandom_range(65535, 1));
      cur_high = cur_low - 16'd1;
    end else begin
      cur_low  = 16'($urandom_range(2000));
      cur_high = 16'($urandom_range(65535, 20000));
    end
    sel = $urandom_range(4);
    case (sel)
      0: thr = 16'd0;
      1: thr = 16'hFFFF;
      4: thr = 16'($urandom);
      default: thr = 16'($urandom_range(200));
    endcase
    write_reg(REG_ANGLE_START, 16'($urandom));
    write_reg(REG_ANGLE_STEP, a_step);
    write_reg(REG_RANGE_LOW, cur_low);
    write_reg(REG_RANGE_HIGH, cur_high);
    write_reg(REG_JUMP_THRESHOLD, thr);
    if ($urandom_range(2) == 0)
      write_reg(3'($urandom_range(SPARE_INDEX_LAST, SPARE_INDEX_FIRST)), 16'($urandom));
  endtask

  // Whole scans; ranges mostly walk slowly so that neighbors stay close and
  // the jump test sees both sides of the threshold.
  task automatic run_scans(input int n_items);
    int sent, scan_len, k, sel, walk_r;
    sent = 0;
    walk_r = $urandom_range(cur_high, cur_low);
    while (sent < n_items) begin
      scan_len = $urandom_range(40, 1);
      for (k = 1; k <= scan_len; k++) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          walk_r = walk_r + $urandom_range(80) - 40;
          if (walk_r < 0) walk_r = 0;
          if (walk_r > 65535) walk_r = 65535;
        end else if (sel < 75) begin
          walk_r = $urandom_range(65535);
        end else if (sel < 90) begin
          case ($urandom_range(3))
            0: walk_r = int'(16'(cur_low - 16'd1));
            1: walk_r = int'(cur_low);
            2: walk_r = int'(cur_high);
            default: walk_r = int'(16'(cur_high + 16'd1));
          endcase
        end else begin
          walk_r = $urandom_range(1) ? 65535 : 0;
        end
        send_sample(16'(walk_r), k == scan_len);
        sent++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 71;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: full window, fixed angle zero, threshold 40.
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd1000, 1'b1);
    wait_drained();

    // Quarter-turn steps walk all quadrants; window edges on both sides,
    // then a rejected last sample that only closes the scan.
    write_reg(REG_ANGLE_START, 16'h4000);
    write_reg(REG_ANGLE_STEP, 16'h4000);
    write_reg(REG_RANGE_LOW, 16'd100);
    write_reg(REG_RANGE_HIGH, 16'd60000);
    write_reg(REG_JUMP_THRESHOLD, 16'd0);
    write_reg(SPARE_INDEX_FIRST, 16'($urandom));
    send_sample(16'd99, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd60000, 1'b0);
    send_sample(16'd60001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b1);
    wait_drained();

    // A new start angle takes effect at once, even in the middle of a scan.
    send_sample(16'd500, 1'b0);
    wait_drained();
    write_reg(REG_ANGLE_START, 16'hC000);
    send_sample(16'd500, 1'b1);
    wait_drained();

    // Largest threshold and full window around the negative x axis.
    write_reg(REG_RANGE_LOW, 16'd0);
    write_reg(REG_RANGE_HIGH, 16'hFFFF);
    write_reg(REG_JUMP_THRESHOLD, 16'hFFFF);
    write_reg(REG_ANGLE_STEP, 16'd1);
    write_reg(REG_ANGLE_START, 16'h8000);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b1);
    wait_drained();

    // Empty window: only the end marker comes out.
    write_reg(REG_RANGE_LOW, 16'd5000);
    write_reg(REG_RANGE_HIGH, 16'd4999);
    send_sample(16'd4999, 1'b0);
    send_sample(16'd5000, 1'b0);
    send_sample(16'd5000, 1'b1);
    wait_drained();

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin send_idle_pct = 22; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int p = 0; p < 3; p++) begin
        pick_settings();
        run_scans(PHASE_ITEMS);
        wait_drained();
      end
    end

    if (mismatch_count == 0 && points_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
